@@ rtl/core/mvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvs_pkg: shared types and constants for the mode-of-value-set block
// Token layout passed from cell to cell and default sizing.
// ----------------------------------------------------------------------------
package mvs_pkg;

  localparam int VALUE_W          = 32;
  localparam int OUT_CNT_W        = 16;
  localparam int MAX_DISTINCT_DEF = 64;
  localparam int COUNT_BITS_DEF   = 16;

  typedef struct packed {
    logic               valid;
    logic               has_value;
    logic               last;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] best_val;
  } tok_t;

endpackage

@@ rtl/core/mode_of_value_set.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mode_of_value_set: most frequent value of a streamed set
// Usage:
//   Input channel (in_valid/in_ready) carries one 32-bit value per item and
//   in_last_item marks the final value of a set. After the last item one
//   result item appears on the out_ channel: mode value, its saturated count,
//   a found flag (some value repeats) and an overflow flag (a distinct value
//   was dropped because all cells were taken).
//   Each item walks a row of MAX_DISTINCT cell registers in order; the result
//   is registered in the tail as the last item leaves the final cell.
//   Items enter one per cycle while the row is not held; the row is a
//   pipeline and the cells clear behind the last item of a set, so the next
//   set may follow at once. Throughput is one item per cycle unless held.
//   When a result waits and out_ready is low, the row holds once the next
//   last item reaches the tail; in_ready then drops until the result leaves.
//   Synchronous reset empties every cell and drops any item in flight.
// ----------------------------------------------------------------------------
module mode_of_value_set
  import mvs_pkg::*;
#(
  parameter int MAX_DISTINCT = MAX_DISTINCT_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VALUE_W-1:0]   in_value,
  input  logic                 in_last_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VALUE_W-1:0]   out_mode_value,
  output logic [OUT_CNT_W-1:0] out_repeat_count,
  output logic                 out_mode_found,
  output logic                 out_overflow
);

  tok_t                  tok  [MAX_DISTINCT+1];
  logic [COUNT_BITS-1:0] best [MAX_DISTINCT+1];
  logic                  advance;

  assign tok[0] = '{valid: in_valid, has_value: 1'b1, last: in_last_item,
                    value: in_value, best_val: '0};
  assign best[0] = COUNT_BITS'(1);

  assign in_ready = advance;

  for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
    mvs_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (advance),
      .tok_i      (tok[i]),
      .best_cnt_i (best[i]),
      .tok_o      (tok[i+1]),
      .best_cnt_o (best[i+1])
    );
  end

  mvs_out #(
    .COUNT_BITS(COUNT_BITS)
  ) u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .tok_i            (tok[MAX_DISTINCT]),
    .best_cnt_i       (best[MAX_DISTINCT]),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mode_value   (out_mode_value),
    .out_repeat_count (out_repeat_count),
    .out_mode_found   (out_mode_found),
    .out_overflow     (out_overflow)
  );

endmodule

@@ rtl/core/mvs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvs_cell: one counting cell of the chain
// Holds one distinct value and its count; matches, allocates, scans for the
// best count on the last item of a set and clears itself behind that item.
// ----------------------------------------------------------------------------
module mvs_cell
  import mvs_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  tok_t                  tok_i,
  input  logic [COUNT_BITS-1:0] best_cnt_i,
  output tok_t                  tok_o,
  output logic [COUNT_BITS-1:0] best_cnt_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  logic [VALUE_W-1:0]    val_r, val_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_upd;
  tok_t                  tok_r, tok_nxt;
  logic [COUNT_BITS-1:0] best_r, best_nxt;
  logic                  used, live, match, alloc;

  always_comb begin
    used    = (cnt_r != '0);
    live    = tok_i.valid && tok_i.has_value;
    match   = live && used && (val_r == tok_i.value);
    alloc   = live && !used;
    cnt_upd = cnt_r;
    if (match && (cnt_r != CNT_MAX)) cnt_upd = cnt_r + CNT_ONE;
    if (alloc) cnt_upd = CNT_ONE;
    val_nxt = alloc ? tok_i.value : val_r;
    cnt_nxt = cnt_upd;
    tok_nxt = tok_i;
    best_nxt = best_cnt_i;
    tok_nxt.has_value = tok_i.has_value && !(match || alloc);
    if (tok_i.valid && tok_i.last) begin
      if (cnt_upd > best_cnt_i) begin
        best_nxt         = cnt_upd;
        tok_nxt.best_val = alloc ? tok_i.value : val_r;
      end
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      tok_r.valid <= 1'b0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r  <= val_nxt;
      best_r <= best_nxt;
    end
  end

  assign tok_o      = tok_r;
  assign best_cnt_o = best_r;

endmodule

@@ rtl/core/mvs_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvs_out: chain tail and result register
// Tracks dropped values of the current set and forms the result item.
// ----------------------------------------------------------------------------
module mvs_out
  import mvs_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tok_t                  tok_i,
  input  logic [COUNT_BITS-1:0] best_cnt_i,
  output logic                  advance,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_W-1:0]    out_mode_value,
  output logic [OUT_CNT_W-1:0]  out_repeat_count,
  output logic                  out_mode_found,
  output logic                  out_overflow
);

  localparam int W = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
  localparam logic [W-1:0] SAT = W'({OUT_CNT_W{1'b1}});
  localparam logic [W-1:0] ONE = W'(1);

  logic                 valid_r, valid_nxt;
  logic                 drop_r, drop_nxt;
  logic [VALUE_W-1:0]   val_r;
  logic [OUT_CNT_W-1:0] cnt_r;
  logic                 found_r, ovf_r;
  logic [W-1:0]         best_w;
  logic                 done;

  always_comb begin
    best_w    = W'(best_cnt_i);
    done      = tok_i.valid && tok_i.last;
    advance   = !(done && valid_r && !out_ready);
    valid_nxt = valid_r && !out_ready;
    drop_nxt  = drop_r;
    if (advance && tok_i.valid) begin
      drop_nxt = drop_r || tok_i.has_value;
      if (tok_i.last) begin
        valid_nxt = 1'b1;
        drop_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) begin
      val_r   <= tok_i.best_val;
      cnt_r   <= (best_w > SAT) ? OUT_CNT_W'(SAT) : OUT_CNT_W'(best_w);
      found_r <= (best_w > ONE);
      ovf_r   <= drop_r || tok_i.has_value;
    end
  end

  assign out_valid        = valid_r;
  assign out_mode_value   = val_r;
  assign out_repeat_count = cnt_r;
  assign out_mode_found   = found_r;
  assign out_overflow     = ovf_r;

`ifndef SYNTHESIS
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |-> (valid_r && !out_ready))
    else $error("chain stalled without a waiting result");
  a_no_repeat_form: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !found_r) |-> (cnt_r == OUT_CNT_W'(1) && val_r == '0))
    else $error("result without repeat is malformed");
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && found_r) |-> (cnt_r > OUT_CNT_W'(1)))
    else $error("found result with count below two");
  a_drop_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && done) |=> !drop_r)
    else $error("dropped flag survived end of set");
`endif

endmodule
